### sv/fpa_pkg.sv
// Shared types and constants for the fixed-point ALU.
// No dependencies; every other file of the block imports this package.
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int WORD_W        = 32;

    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_MIN      = 4'd4;
    localparam logic [3:0] OP_MAX      = 4'd5;
    localparam logic [3:0] OP_INC      = 4'd6;
    localparam logic [3:0] OP_DEC      = 4'd7;
    localparam logic [3:0] OP_TO_INT   = 4'd8;
    localparam logic [3:0] OP_FROM_INT = 4'd9;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } fpa_in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic               divide_by_zero;
    } fpa_out_t;

    // Everything that rides alongside the divider pipeline.
    typedef struct packed {
        logic [31:0] result;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        dz;
        logic        is_div;
        logic        neg;
    } fpa_side_t;

endpackage

### sv/fpa_prep.sv
// Front stage: decode, compare, simple operations, multiplier and divider operand setup.
// Depends on fpa_pkg.
module fpa_prep #(
    parameter int FRACTION_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int NW            = fpa_pkg::WORD_W + fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ce,
    input  logic                  in_valid,
    input  fpa_pkg::fpa_in_t      in_data,
    output logic                  valid_reg,
    output fpa_pkg::fpa_side_t    side_reg,
    output logic                  is_mul_reg,
    output logic signed [63:0]    prod_reg,
    output logic [NW-1:0]         dvd_reg,
    output logic [31:0]           dvs_reg
);
    import fpa_pkg::*;

    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               lt;
    logic               gt;
    logic               eq;
    logic [31:0]        abs_a;
    logic [31:0]        abs_b;
    fpa_side_t          side_next;

    assign a     = in_data.operand_a;
    assign b     = in_data.operand_b;
    assign lt    = a < b;
    assign gt    = a > b;
    assign eq    = a == b;
    assign abs_a = a[31] ? 32'(-a) : a;
    assign abs_b = b[31] ? 32'(-b) : b;

    always_comb begin
        side_next        = '0;
        side_next.lt     = lt;
        side_next.eq     = eq;
        side_next.gt     = gt;
        side_next.is_div = in_data.kind == OP_DIV;
        side_next.neg    = a[31] ^ b[31];
        side_next.dz     = (in_data.kind == OP_DIV) && (b == 32'sd0);
        case (in_data.kind)
            OP_ADD:      side_next.result = a + b;
            OP_SUB:      side_next.result = a - b;
            OP_MIN:      side_next.result = lt ? a : b;
            OP_MAX:      side_next.result = gt ? a : b;
            OP_INC:      side_next.result = a + 32'sd1;
            OP_DEC:      side_next.result = a - 32'sd1;
            OP_TO_INT:   side_next.result = a >>> FRACTION_BITS;
            OP_FROM_INT: side_next.result = a << FRACTION_BITS;
            default:     side_next.result = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            side_reg   <= side_next;
            is_mul_reg <= in_data.kind == OP_MUL;
            prod_reg   <= 64'(a) * 64'(b);
            dvd_reg    <= NW'(abs_a) << FRACTION_BITS;
            dvs_reg    <= abs_b;
        end
    end

endmodule

### sv/fpa_div_stage.sv
// One registered step of the restoring divider: one quotient bit per stage.
// Depends on fpa_pkg for the side-band struct.
module fpa_div_stage #(
    parameter int NW = fpa_pkg::WORD_W + fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                ce,
    input  logic                in_valid,
    input  fpa_pkg::fpa_side_t  in_side,
    input  logic [31:0]         in_rem,
    input  logic [NW-1:0]       in_dq,
    input  logic [31:0]         in_dvs,
    output logic                valid_reg,
    output fpa_pkg::fpa_side_t  side_reg,
    output logic [31:0]         rem_reg,
    output logic [NW-1:0]       dq_reg,
    output logic [31:0]         dvs_reg
);
    import fpa_pkg::*;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        fits;

    // The dividend shifts out of the top while quotient bits shift in below.
    assign trial = {in_rem, in_dq[NW-1]};
    assign diff  = trial - {1'b0, in_dvs};
    assign fits  = !diff[32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            side_reg <= in_side;
            rem_reg  <= fits ? diff[31:0] : trial[31:0];
            dq_reg   <= {in_dq[NW-2:0], fits};
            dvs_reg  <= in_dvs;
        end
    end

endmodule

### sv/fixed_point_alu.sv
// Top level of the pipelined Q-format fixed-point ALU.
// Depends on fpa_pkg, fpa_prep and fpa_div_stage.
//
//  Channel | Ports                          | Payload
//  --------+--------------------------------+-----------
//  input   | s_valid, s_ready, s_data       | fpa_in_t
//  result  | m_valid, m_ready, m_data       | fpa_out_t
//
// Every transaction passes from acceptance to the result register through one
// front stage, one divider stage per quotient bit (32 + FRACTION_BITS of them),
// and the output register; the unrolled divider sets the pipeline depth. One
// transaction can enter in every clock cycle unless the pipeline is stalled.
// Reset (aresetn low at a clock edge) clears every stage's valid bit.
// The whole pipeline advances together whenever the output register is empty
// or its result is being taken; otherwise every stage holds.
module fixed_point_alu #(
    parameter int FRACTION_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fpa_pkg::fpa_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fpa_pkg::fpa_out_t m_data
);
    import fpa_pkg::*;

    // Dividend width: |operand_a| is at most 2^31, shifted by the fraction bits.
    localparam int NW = WORD_W + FRACTION_BITS;

    logic ce;
    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    // Front stage.
    logic               p_valid;
    fpa_side_t          p_side;
    logic               p_is_mul;
    logic signed [63:0] p_prod;
    logic [NW-1:0]      p_dvd;
    logic [31:0]        p_dvs;

    fpa_prep #(
        .FRACTION_BITS(FRACTION_BITS),
        .NW           (NW)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .valid_reg (p_valid),
        .side_reg  (p_side),
        .is_mul_reg(p_is_mul),
        .prod_reg  (p_prod),
        .dvd_reg   (p_dvd),
        .dvs_reg   (p_dvs)
    );

    // The registered product is scaled back here and folded into the side-band
    // result before it enters the divider chain.
    logic signed [63:0] prod_sh;
    fpa_side_t          side0;
    assign prod_sh = p_prod >>> FRACTION_BITS;
    always_comb begin
        side0 = p_side;
        if (p_is_mul) begin
            side0.result = prod_sh[31:0];
        end
    end

    // Divider chain, one stage per quotient bit.
    logic                v_st   [NW+1];
    fpa_side_t           side_st[NW+1];
    logic [31:0]         rem_st [NW+1];
    logic [NW-1:0]       dq_st  [NW+1];
    logic [31:0]         dvs_st [NW+1];

    assign v_st[0]    = p_valid;
    assign side_st[0] = side0;
    assign rem_st[0]  = '0;
    assign dq_st[0]   = p_dvd;
    assign dvs_st[0]  = p_dvs;

    for (genvar i = 0; i < NW; i++) begin : g_div
        fpa_div_stage #(
            .NW(NW)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ce       (ce),
            .in_valid (v_st[i]),
            .in_side  (side_st[i]),
            .in_rem   (rem_st[i]),
            .in_dq    (dq_st[i]),
            .in_dvs   (dvs_st[i]),
            .valid_reg(v_st[i+1]),
            .side_reg (side_st[i+1]),
            .rem_reg  (rem_st[i+1]),
            .dq_reg   (dq_st[i+1]),
            .dvs_reg  (dvs_st[i+1])
        );
    end

    // Final stage: sign the quotient and pick the result word.
    fpa_side_t   last_side;
    logic [NW-1:0] quot;
    logic [31:0] quot_word;
    fpa_out_t    out_next;
    logic        m_valid_reg;
    fpa_out_t    m_data_reg;

    assign last_side = side_st[NW];
    assign quot      = last_side.neg ? NW'(-dq_st[NW]) : dq_st[NW];
    assign quot_word = quot[31:0];

    always_comb begin
        out_next.a_less         = last_side.lt;
        out_next.a_equal        = last_side.eq;
        out_next.a_greater      = last_side.gt;
        out_next.divide_by_zero = last_side.dz;
        if (last_side.is_div) begin
            out_next.result_value = last_side.dz ? '0 : quot_word;
        end else begin
            out_next.result_value = last_side.result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= v_st[NW];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Exactly one comparison outcome is reported with every result.
    a_cmp_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot({m_data.a_less, m_data.a_equal, m_data.a_greater}))
        else $error("comparison flags not one-hot");

    // A division by zero always yields a zero word.
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.divide_by_zero) |-> (m_data.result_value == 32'sd0))
        else $error("divide by zero with nonzero result");

    // A result that is not taken stays offered with its payload unchanged.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

endmodule
